// ===== src/grfw_pkg.sv =====
// ----------------------------------------------------------------------------
// grfw_pkg - shared types and constants of the glyph row framebuffer writer
// Layout constants, mask tables, and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package grfw_pkg;

    // Shadow store geometry
    localparam int STORE_AW    = 16;
    localparam int STORE_DEPTH = 1 << STORE_AW;

    // Cell geometry
    localparam int CELL_HEIGHT      = 12;
    localparam int WIDE_CELL_HEIGHT = 10;
    localparam int WIDE_ROW_BYTES   = WIDE_CELL_HEIGHT * 160;

    // Screen constants
    localparam logic [19:0] CGA_BASE    = 20'hB8000;
    localparam logic [19:0] VGA_BASE    = 20'hA0000;
    localparam logic [17:0] INTERLEAVE  = 18'h02000;
    localparam logic [17:0] SIX_PX_LEFT = 18'd120;
    localparam logic [7:0]  FULL_MASK   = 8'hFF;

    // Input kinds
    localparam logic [1:0] KIND_SIX    = 2'd0;
    localparam logic [1:0] KIND_EIGHT  = 2'd1;
    localparam logic [1:0] KIND_WIDE   = 2'd2;
    localparam logic [1:0] KIND_FORGET = 2'd3;

    // Video mode currently programmed
    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_CGA  = 2'd1,
        MODE_VGA  = 2'd2
    } t_mode;

    // Controller -> datapath commands
    typedef struct packed {
        logic idle;      // ready for a new request
        logic forget;    // drop the current video mode
        logic mode_evt;  // emit mode event, take new mode
        logic clr_step;  // clear one shadow byte
        logic rd;        // read the selected shadow byte
        logic mrg;       // merge, write back, emit if changed
        logic second;    // selects the second byte of the row
        logic flush;     // release the held result as the last one
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic accepted;
        logic kind_forget;
        logic mode_change;
        logic row_ok;
        logic has_second;
        logic clr_last;
        logic out_free;
    } t_sts;

    // One result without its last flag
    typedef struct packed {
        logic        event_res;
        logic        video_mode;
        logic [19:0] address;
        logic [7:0]  data;
    } t_res;

    // Six-pixel cells: mask of the first byte by cell phase
    function automatic logic [7:0] left_mask(input logic [1:0] ph);
        logic [7:0] m;
        case (ph)
            2'd0:    m = 8'hFC;
            2'd1:    m = 8'h03;
            2'd2:    m = 8'h0F;
            default: m = 8'h3F;
        endcase
        return m;
    endfunction

    // Six-pixel cells: mask of the spill byte by cell phase
    function automatic logic [7:0] right_mask(input logic [1:0] ph);
        logic [7:0] m;
        case (ph)
            2'd1:    m = 8'hF0;
            2'd2:    m = 8'hC0;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Rotate left by twice the phase
    function automatic logic [7:0] rot_phase(input logic [7:0] p, input logic [1:0] ph);
        logic [7:0] r;
        case (ph)
            2'd0:    r = p;
            2'd1:    r = {p[5:0], p[7:6]};
            2'd2:    r = {p[3:0], p[7:4]};
            default: r = {p[1:0], p[7:2]};
        endcase
        return r;
    endfunction

endpackage

// ===== src/grfw_ifs.sv =====
// ----------------------------------------------------------------------------
// grfw_ifs - channel interfaces of the glyph row framebuffer writer
// Glyph row request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface grfw_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] position;
    logic [3:0]  row;
    logic [7:0]  pattern;

    modport source (output valid, kind, position, row, pattern, input ready);
    modport sink   (input valid, kind, position, row, pattern, output ready);
endinterface

interface grfw_res_if;
    logic        valid;
    logic        ready;
    logic        event_res;
    logic        video_mode;
    logic [19:0] address;
    logic [7:0]  data;
    logic        last;

    modport source (output valid, event_res, video_mode, address, data, last,
                    input ready);
    modport sink   (input valid, event_res, video_mode, address, data, last,
                    output ready);
endinterface

interface grfw_cfg_if;
    logic valid;
    logic ready;
    logic display_select;

    modport source (output valid, display_select, input ready);
    modport sink   (input valid, display_select, output ready);
endinterface

// ===== src/grfw_ctrl.sv =====
// ----------------------------------------------------------------------------
// grfw_ctrl - sequencing controller
// Walks each request through offset calculation, the optional mode event and
// shadow clear, up to two read-modify-writes and a flush, or forgets the mode.
// ----------------------------------------------------------------------------
module grfw_ctrl
    import grfw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_CALC1 = 9'b000000100,
        S_CALC2 = 9'b000001000,
        S_CALC3 = 9'b000010000,
        S_MODE  = 9'b000100000,
        S_RD    = 9'b001000000,
        S_MRG   = 9'b010000000,
        S_FLUSH = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_after_mode, n_after_mode;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_second     = r_second;
        n_after_mode = r_after_mode;
        o_cmd        = '0;
        o_cmd.second = r_second;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_second = 1'b0;
                    if (!r_after_mode) begin
                        n_state = S_IDLE;
                    end else if (i_sts.row_ok) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_sts.accepted) begin
                    n_state = S_CALC1;
                end
            end
            S_CALC1: begin
                if (i_sts.kind_forget) begin
                    o_cmd.forget = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_CALC2;
                end
            end
            S_CALC2: n_state = S_CALC3;
            S_CALC3: n_state = S_MODE;
            S_MODE: begin
                n_second = 1'b0;
                if (i_sts.mode_change) begin
                    if (i_sts.out_free) begin
                        o_cmd.mode_evt = 1'b1;
                        n_after_mode   = 1'b1;
                        n_state        = S_CLR;
                    end
                end else if (i_sts.row_ok) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MRG;
            end
            S_MRG: begin
                if (i_sts.out_free) begin
                    o_cmd.mrg = 1'b1;
                    if (!r_second && i_sts.has_second) begin
                        n_second = 1'b1;
                        n_state  = S_RD;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers; reset starts with a clear pass of the shadow store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_second     <= 1'b0;
            r_after_mode <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_second     <= n_second;
            r_after_mode <= n_after_mode;
        end
    end

endmodule

// ===== src/grfw_dpath.sv =====
// ----------------------------------------------------------------------------
// grfw_dpath - datapath of the glyph row framebuffer writer
// Request latch, offset pipeline, shadow store, merge logic, mode register,
// and the held/output result registers.
// ----------------------------------------------------------------------------
module grfw_dpath
    import grfw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    grfw_item_if.sink   i_item,
    grfw_cfg_if.sink    i_cfg,
    grfw_res_if.source  o_res,
    input  t_cmd        i_cmd,
    output t_sts        o_sts
);

    // Latched request
    logic [1:0]  r_kind;
    logic [15:0] r_pos;
    logic [3:0]  r_row;
    logic [7:0]  r_pat;

    // Offset pipeline
    logic [9:0]          r_q;
    logic [6:0]          r_x;
    logic [4:0]          r_y;
    logic [STORE_AW-1:0] r_off;

    // Control state
    logic                r_disp_sel;
    t_mode               r_mode;
    logic [STORE_AW-1:0] r_clr_addr;
    logic                r_hold_vld;
    logic                r_out_vld;

    // Result payload
    t_res r_hold;
    t_res r_out;
    logic r_out_last;

    // Shadow store
    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] r_rdata;

    logic                w_accept;
    logic                w_six;
    logic                w_wide;
    logic [23:0]         w_qprod;
    logic [16:0]         w_q80;
    logic [14:0]         w_tprod;
    logic [10:0]         w_t24;
    logic [17:0]         w_wide_off;
    logic [17:0]         w_py;
    logic [17:0]         w_px6;
    logic [17:0]         w_pxb;
    logic [17:0]         w_step;
    logic [17:0]         w_narrow_off;
    logic [STORE_AW-1:0] w_delta;
    logic [STORE_AW-1:0] w_baddr;
    logic [7:0]          w_val;
    logic [7:0]          w_mask;
    logic [7:0]          w_nb;
    logic                w_changed;
    logic                w_we;
    logic [STORE_AW-1:0] w_waddr;
    logic [7:0]          w_wdata;
    logic                w_push;
    t_res                w_new;
    t_mode               w_want;

    // Request channel
    assign i_item.ready = i_cmd.idle;
    assign w_accept     = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_item.kind;
            r_pos  <= i_item.position;
            r_row  <= i_item.row;
            r_pat  <= i_item.pattern;
        end
    end

    // Configuration register; taken only between requests
    assign i_cfg.ready = i_cmd.idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_sel <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_disp_sel <= i_cfg.display_select;
        end
    end

    assign w_six  = (r_kind == KIND_SIX);
    assign w_wide = (r_kind == KIND_WIDE);

    // Stage 1: q = position / 80 via (position >> 4) / 5 by reciprocal
    assign w_qprod = {12'd0, r_pos[15:4]} * 24'd3277;

    // Stage 2: x = position mod 80, y = q mod 24 via (q >> 3) / 3
    assign w_q80   = {7'd0, r_q} * 17'd80;
    assign w_tprod = {8'd0, r_q[9:3]} * 15'd171;
    assign w_t24   = {5'd0, w_tprod[14:9]} * 11'd24;

    // Stage 3: byte offsets of both layouts
    assign w_wide_off = {13'd0, r_y} * 18'(WIDE_ROW_BYTES) + {11'd0, r_x}
                      + {14'd0, r_row} * 18'd160;
    assign w_py       = {14'd0, r_pos[9:6]} * 18'(CELL_HEIGHT);
    assign w_px6      = {12'd0, r_pos[5:0]} * 18'd6 + SIX_PX_LEFT;
    assign w_pxb      = w_six ? (w_px6 >> 3) : ({12'd0, r_pos[5:0]} + 18'd8);
    assign w_step     = {15'd0, r_row[3:1]} * 18'd80 + (r_row[0] ? INTERLEAVE : 18'd0);
    assign w_narrow_off = (w_py >> 1) * 18'd80 + w_pxb + w_step;

    always_ff @(posedge i_clk) begin
        r_q   <= w_qprod[23:14];
        r_x   <= r_pos[6:0] - w_q80[6:0];
        r_y   <= r_q[4:0] - w_t24[4:0];
        r_off <= w_wide ? w_wide_off[STORE_AW-1:0] : w_narrow_off[STORE_AW-1:0];
    end

    // Byte selection and merge
    assign w_delta = w_wide ? STORE_AW'(80) : STORE_AW'(1);
    assign w_baddr = i_cmd.second ? (r_off + w_delta) : r_off;
    assign w_val   = w_six ? rot_phase(r_pat, r_pos[1:0]) : r_pat;
    assign w_mask  = !w_six ? FULL_MASK
                   : (i_cmd.second ? right_mask(r_pos[1:0]) : left_mask(r_pos[1:0]));
    assign w_nb    = (w_val & w_mask) | (r_rdata & ~w_mask);
    assign w_changed = (w_nb != r_rdata);

    // Shadow store port
    assign w_we    = i_cmd.clr_step || (i_cmd.mrg && w_changed);
    assign w_waddr = i_cmd.clr_step ? r_clr_addr : w_baddr;
    assign w_wdata = i_cmd.clr_step ? 8'd0 : w_nb;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[w_baddr];
        end
    end

    // Clear pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + STORE_AW'(1);
        end
    end

    // Video mode register
    assign w_want = w_wide ? MODE_VGA : MODE_CGA;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
        end else if (i_cmd.forget) begin
            r_mode <= MODE_NONE;
        end else if (i_cmd.mode_evt) begin
            r_mode <= w_want;
        end
    end

    // New result: mode event or changed screen byte
    always_comb begin
        w_new = '0;
        if (i_cmd.mode_evt) begin
            w_new.event_res  = 1'b1;
            w_new.video_mode = w_wide;
        end else begin
            w_new.video_mode = w_wide;
            w_new.address    = (w_wide ? VGA_BASE : CGA_BASE)
                             + {{(20 - STORE_AW){1'b0}}, w_baddr};
            w_new.data       = w_nb;
        end
    end

    assign w_push = i_cmd.mode_evt || (i_cmd.mrg && w_changed && !r_disp_sel);

    // Held result and output register: a result is held until the next one
    // or the end of the request decides its last flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_hold_vld && (w_push || i_cmd.flush)) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_push) begin
                r_hold_vld <= 1'b1;
            end else if (i_cmd.flush) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_hold <= w_new;
            if (r_hold_vld) begin
                r_out      <= r_hold;
                r_out_last <= 1'b0;
            end
        end else if (i_cmd.flush && r_hold_vld) begin
            r_out      <= r_hold;
            r_out_last <= 1'b1;
        end
    end

    // Result channel
    assign o_res.valid      = r_out_vld;
    assign o_res.event_res  = r_out.event_res;
    assign o_res.video_mode = r_out.video_mode;
    assign o_res.address    = r_out.address;
    assign o_res.data       = r_out.data;
    assign o_res.last       = r_out_last;

    // Status
    assign o_sts.accepted    = w_accept;
    assign o_sts.kind_forget = (r_kind == KIND_FORGET);
    assign o_sts.mode_change = (r_mode != w_want);
    assign o_sts.row_ok      = w_wide ? ({1'b0, r_row} < 5'(WIDE_CELL_HEIGHT))
                                      : ({1'b0, r_row} < 5'(CELL_HEIGHT));
    assign o_sts.has_second  = w_wide || (w_six && (right_mask(r_pos[1:0]) != 8'd0));
    assign o_sts.clr_last    = &r_clr_addr;
    assign o_sts.out_free    = !r_out_vld || o_res.ready;

`ifndef NO_ASSERTIONS
    // A new result only arrives when the held one can move on
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> o_sts.out_free)
        else $error("result pushed while output register busy");

    // Store reads and writes never share a cycle
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && i_cmd.rd))
        else $error("shadow store read and write in the same cycle");

    // Every request ends with its results flushed
    a_idle_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.idle |-> !r_hold_vld)
        else $error("result still held while idle");

    // VGA writes land in the VGA window
    a_vga_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.event_res && r_out.video_mode)
            |-> (r_out.address[19:16] == VGA_BASE[19:16]))
        else $error("VGA write outside its window");
`endif

endmodule

// ===== src/glyph_row_framebuffer_writer.sv =====
// ----------------------------------------------------------------------------
// glyph_row_framebuffer_writer - glyph row placement into a 1-bit shadow screen
// Top level: joins the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one glyph row request (kind, position, row, pattern);
//   o_res returns its screen byte writes and video mode events, with last set
//   on the final one; a request that changes nothing returns no result.
//   i_cfg writes display_select; it is ready only while the block is idle.
// Sequence:
//   A request passes through the offset pipeline, then one read and one merge
//   per byte on the single-port shadow store, then a flush; a row outside the
//   cell skips the read and merge, and a forget request drops the video mode
//   and returns to idle without a flush.
//   A video mode change adds a clear pass over the whole shadow store, one
//   store byte per cycle, during which no request is accepted.
// Reset:
//   i_rst_n (synchronous, active low) clears the control state and starts a
//   clear pass of the whole shadow store before i_item goes ready.
// Stalls:
//   o_res has an output register plus one held result; while that register is
//   full and ready is low, the block waits before pushing further results.
// ----------------------------------------------------------------------------
module glyph_row_framebuffer_writer
    import grfw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    grfw_item_if.sink   i_item,
    grfw_cfg_if.sink    i_cfg,
    grfw_res_if.source  o_res
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    grfw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Datapath and shadow store
    grfw_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cfg   (i_cfg),
        .o_res   (o_res),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule

// ===== verif/grfw_screen_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grfw_screen_checker - result checker of the glyph row framebuffer writer
// Watches the request, configuration and result channels, keeps its own
// mirror of the shadow screen and video mode, predicts the screen writes and
// mode events of each accepted request, and compares every result in order.
// ----------------------------------------------------------------------------
module grfw_screen_checker
    import grfw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    grfw_item_if i_item,
    grfw_cfg_if  i_cfg,
    grfw_res_if  i_res,
    output int   o_fail_count,
    output int   o_outstanding
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        t_res op;
        logic last;
    } t_screen_op;

    // Mirror of the block state
    logic [7:0] shadow_mirror [STORE_DEPTH];
    t_mode      mirror_mode;
    logic       mirror_select;

    // Screen operations still owed by the block, oldest first
    t_screen_op screen_ops_due [$];
    // Operations of the request being worked out
    t_screen_op row_ops [$];
    int         fail_total = 0;

    task automatic flag_mismatch(input string what);
        fail_total++;
        if (fail_total <= PRINT_LIMIT)
            $display("%0t ERROR: %s", $time, what);
    endtask

    task automatic clear_mirror();
        foreach (shadow_mirror[i]) shadow_mirror[i] = 8'h00;
    endtask

    task automatic add_row_op(input logic ev, input logic vm, input logic [19:0] addr,
                              input logic [7:0] data);
        t_screen_op op;
        op.op.event_res  = ev;
        op.op.video_mode = vm;
        op.op.address    = addr;
        op.op.data       = data;
        op.last          = 1'b0;
        row_ops.push_back(op);
    endtask

    // A new layout mode raises an event and wipes the shadow screen
    task automatic enter_mode(input t_mode want);
        if (mirror_mode != want) begin
            add_row_op(1'b1, want == MODE_VGA, 20'h0, 8'h00);
            clear_mirror();
            mirror_mode = want;
        end
    endtask

    // Merge under mask; only a changed byte goes out, and only on the text screen
    task automatic merge_shadow_byte(input int unsigned offset, input logic [7:0] value,
                                     input logic [7:0] mask, input logic [19:0] base,
                                     input logic vm);
        logic [STORE_AW-1:0] idx;
        logic [7:0]          cur;
        logic [7:0]          nb;
        idx = offset[STORE_AW-1:0];
        cur = shadow_mirror[idx];
        nb  = (value & mask) | (cur & ~mask);
        if (nb != cur) begin
            shadow_mirror[idx] = nb;
            if (!mirror_select)
                add_row_op(1'b0, vm, base + 20'(idx), nb);
        end
    endtask

    // Work out every result of one glyph row request
    task automatic place_glyph_row(input logic [1:0] kind, input logic [15:0] pos,
                                   input logic [3:0] row, input logic [7:0] pat);
        int unsigned x, y, py, px, off, step;
        logic [1:0]  ph;
        logic [15:0] twice;
        logic [7:0]  rot, lmask, rmask;
        row_ops.delete();
        if (kind == KIND_FORGET) begin
            mirror_mode = MODE_NONE;
        end else if (kind == KIND_WIDE) begin
            enter_mode(MODE_VGA);
            if (row < WIDE_CELL_HEIGHT) begin
                x   = pos % 80;
                y   = (pos / 80) % 24;
                off = y * WIDE_ROW_BYTES + x + row * 160;
                // each glyph row is drawn on two scan lines
                merge_shadow_byte(off, pat, 8'hFF, VGA_BASE, 1'b1);
                merge_shadow_byte(off + 80, pat, 8'hFF, VGA_BASE, 1'b1);
            end
        end else begin
            enter_mode(MODE_CGA);
            if (row < CELL_HEIGHT) begin
                x    = 32'(pos[5:0]);
                y    = 32'(pos[9:6]);
                py   = y * CELL_HEIGHT;
                // odd scan lines live in the second interleave bank
                step = (row >> 1) * 80 + (row[0] ? INTERLEAVE : 18'h0);
                if (kind == KIND_SIX) begin
                    ph    = pos[1:0];
                    twice = {pat, pat} << (2 * ph);
                    rot   = twice[15:8];
                    case (ph)
                        2'd0:    begin lmask = 8'hFC; rmask = 8'h00; end
                        2'd1:    begin lmask = 8'h03; rmask = 8'hF0; end
                        2'd2:    begin lmask = 8'h0F; rmask = 8'hC0; end
                        default: begin lmask = 8'h3F; rmask = 8'h00; end
                    endcase
                    px  = x * 6 + SIX_PX_LEFT;
                    off = (py >> 1) * 80 + (px >> 3) + step;
                    merge_shadow_byte(off, rot, lmask, CGA_BASE, 1'b0);
                    if (rmask != 8'h00)
                        merge_shadow_byte(off + 1, rot, rmask, CGA_BASE, 1'b0);
                end else begin
                    px  = x * 8 + 64;
                    off = (py >> 1) * 80 + (px >> 3) + step;
                    merge_shadow_byte(off, pat, 8'hFF, CGA_BASE, 1'b0);
                end
            end
        end
        if (row_ops.size() > 0)
            row_ops[row_ops.size() - 1].last = 1'b1;
        foreach (row_ops[i]) screen_ops_due.push_back(row_ops[i]);
    endtask

    // Compare one result with the oldest expectation
    task automatic check_screen_op();
        t_screen_op want;
        if (screen_ops_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result ev=%0b vm=%0b addr=%05h data=%02h",
                                    i_res.event_res, i_res.video_mode, i_res.address,
                                    i_res.data));
        end else begin
            want = screen_ops_due.pop_front();
            if (i_res.event_res !== want.op.event_res || i_res.video_mode !== want.op.video_mode
                || i_res.address !== want.op.address || i_res.data !== want.op.data
                || i_res.last !== want.last)
                flag_mismatch($sformatf(
                    "got ev=%0b vm=%0b addr=%05h data=%02h last=%0b, want %0b %0b %05h %02h %0b",
                    i_res.event_res, i_res.video_mode, i_res.address, i_res.data, i_res.last,
                    want.op.event_res, want.op.video_mode, want.op.address, want.op.data,
                    want.last));
        end
    endtask

    // Channel monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_mirror();
            mirror_mode   = MODE_NONE;
            mirror_select = 1'b0;
            screen_ops_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                mirror_select = i_cfg.display_select;
            if (i_item.valid && i_item.ready)
                place_glyph_row(i_item.kind, i_item.position, i_item.row, i_item.pattern);
            if (i_res.valid && i_res.ready)
                check_screen_op();
        end
        o_outstanding <= screen_ops_due.size();
        o_fail_count  <= fail_total;
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - top of the glyph row framebuffer writer verification
// Drives glyph row requests (a directed set, then random phases with the text
// and hires displays selected), stalls the result channel at random, and
// takes the verdict from the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import grfw_pkg::*;

    localparam int SETTLE_CYCLES = 30;

    logic i_clk;
    logic i_rst_n;

    grfw_item_if row_bus ();
    grfw_cfg_if  cfg_bus ();
    grfw_res_if  res_bus ();

    int fail_count;
    int outstanding;

    // Stimulus state: mode as the block should see it, clear passes allowed
    t_mode       stim_mode  = MODE_NONE;
    int          clears_left = 0;
    int          burst_left  = 0;
    int          ready_run   = 0;
    logic        have_prev   = 1'b0;
    logic [1:0]  prev_kind;
    logic [15:0] prev_pos;
    logic [3:0]  prev_row;
    logic [7:0]  prev_pat;

    glyph_row_framebuffer_writer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (row_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    grfw_screen_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (row_bus),
        .i_cfg         (cfg_bus),
        .i_res         (res_bus),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Idle length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    // Sender gap, with occasional back-to-back bursts
    function automatic int next_send_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 99) < 5) begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if ($urandom_range(0, 99) < 40) return 0;
        return pick_gap();
    endfunction

    // Result receiver: alternating ready and stall stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            ready_run     <= 0;
        end else if (ready_run > 0) begin
            ready_run <= ready_run - 1;
        end else if (res_bus.ready) begin
            res_bus.ready <= 1'b0;
            ready_run     <= pick_gap() - 1;
        end else begin
            res_bus.ready <= 1'b1;
            ready_run     <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(0, 40);
        end
    end

    // One glyph row request; returns just after the accepting edge
    task automatic send_row(input logic [1:0] kind, input logic [15:0] pos,
                            input logic [3:0] row, input logic [7:0] pat);
        int gap;
        gap = next_send_gap();
        if (gap > 0) begin
            row_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        row_bus.valid    <= 1'b1;
        row_bus.kind     <= kind;
        row_bus.position <= pos;
        row_bus.row      <= row;
        row_bus.pattern  <= pat;
        @(posedge i_clk);
        while (!row_bus.ready) @(posedge i_clk);
    endtask

    task automatic write_display_select(input logic sel);
        cfg_bus.valid          <= 1'b1;
        cfg_bus.display_select <= sel;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Wait for every expected result, then let the block settle
    task automatic wait_until_drained();
        row_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random request; layout switches are rationed since each costs a clear pass
    task automatic send_random_row();
        int          r;
        logic [1:0]  kind;
        logic [15:0] pos;
        logic [3:0]  row;
        logic [7:0]  pat;
        t_mode       want;
        r = $urandom_range(0, 99);
        if (r < 10 && have_prev) begin
            // repeat of the last request: nothing changes
            kind = prev_kind;
            pos  = prev_pos;
            row  = prev_row;
            pat  = prev_pat;
        end else begin
            if (r < 12 && clears_left > 0)
                kind = KIND_FORGET;
            else if (r < 16)
                kind = 2'($urandom_range(0, 2));
            else if (stim_mode == MODE_VGA)
                kind = KIND_WIDE;
            else
                kind = 2'($urandom_range(0, 1));
            pos = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 99) < 85)
                row = (kind == KIND_WIDE) ? 4'($urandom_range(0, WIDE_CELL_HEIGHT - 1))
                                          : 4'($urandom_range(0, CELL_HEIGHT - 1));
            else
                row = (kind == KIND_WIDE) ? 4'($urandom_range(WIDE_CELL_HEIGHT, 15))
                                          : 4'($urandom_range(CELL_HEIGHT, 15));
            r = $urandom_range(0, 9);
            pat = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        end
        if (kind == KIND_FORGET) begin
            if (stim_mode != MODE_NONE && clears_left > 0)
                clears_left--;
            stim_mode = MODE_NONE;
        end else begin
            want = (kind == KIND_WIDE) ? MODE_VGA : MODE_CGA;
            if (want != stim_mode && stim_mode != MODE_NONE) begin
                if (clears_left > 0)
                    clears_left--;
                else if (stim_mode == MODE_VGA)
                    kind = KIND_WIDE;
                else
                    kind = 2'($urandom_range(0, 1));
            end
            stim_mode = (kind == KIND_WIDE) ? MODE_VGA : MODE_CGA;
        end
        prev_kind = kind;
        prev_pos  = pos;
        prev_row  = row;
        prev_pat  = pat;
        have_prev = 1'b1;
        send_row(kind, pos, row, pat);
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n                = 1'b0;
        row_bus.valid          = 1'b0;
        row_bus.kind           = KIND_SIX;
        row_bus.position       = 16'h0;
        row_bus.row            = 4'h0;
        row_bus.pattern        = 8'h00;
        cfg_bus.valid          = 1'b0;
        cfg_bus.display_select = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_display_select(1'b0);

        // Directed: phases, interleave, field extremes, ignored rows, mode changes
        send_row(KIND_SIX,    16'h0000, 4'd0,  8'hFF);
        send_row(KIND_SIX,    16'h0001, 4'd1,  8'hFF);
        send_row(KIND_SIX,    16'h0002, 4'd2,  8'hA5);
        send_row(KIND_SIX,    16'h0003, 4'd3,  8'h5A);
        send_row(KIND_SIX,    16'h0003, 4'd3,  8'h5A);
        send_row(KIND_SIX,    16'hFFFF, 4'd11, 8'hFF);
        send_row(KIND_SIX,    16'h03C0, 4'd12, 8'hFF);
        send_row(KIND_EIGHT,  16'h0000, 4'd0,  8'h81);
        send_row(KIND_EIGHT,  16'hFFFF, 4'd11, 8'h00);
        send_row(KIND_EIGHT,  16'h003F, 4'd15, 8'hFF);
        send_row(KIND_EIGHT,  16'h1234, 4'd5,  8'hFF);
        send_row(KIND_SIX,    16'h0001, 4'd0,  8'h00);
        send_row(KIND_WIDE,   16'h0000, 4'd0,  8'hFF);
        send_row(KIND_WIDE,   16'hFFFF, 4'd9,  8'h3C);
        send_row(KIND_WIDE,   16'd1919, 4'd9,  8'hFF);
        send_row(KIND_WIDE,   16'd79,   4'd10, 8'hFF);
        send_row(KIND_WIDE,   16'd80,   4'd15, 8'hFF);
        send_row(KIND_WIDE,   16'h0000, 4'd0,  8'hFF);
        send_row(KIND_FORGET, 16'hFFFF, 4'd15, 8'hFF);
        send_row(KIND_WIDE,   16'd5,    4'd12, 8'h00);
        send_row(KIND_EIGHT,  16'd7,    4'd4,  8'h00);
        send_row(KIND_EIGHT,  16'd7,    4'd4,  8'hC3);
        stim_mode = MODE_CGA;

        // Text screen visible
        clears_left = 2;
        repeat (200) send_random_row();
        wait_until_drained();

        // Hires visible: shadow only, mode events still come out
        write_display_select(1'b1);
        send_row(stim_mode == MODE_VGA ? KIND_SIX : KIND_WIDE, 16'($urandom_range(0, 65535)),
                 4'd0, 8'hFF);
        stim_mode   = (stim_mode == MODE_VGA) ? MODE_CGA : MODE_VGA;
        have_prev   = 1'b0;
        clears_left = 1;
        repeat (70) send_random_row();
        wait_until_drained();

        // Text screen again, over what hires left in the shadow store
        write_display_select(1'b0);
        clears_left = 1;
        repeat (100) send_random_row();
        wait_until_drained();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Run limit
    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/grfw_pkg.sv
src/grfw_ifs.sv
src/grfw_ctrl.sv
src/grfw_dpath.sv
src/glyph_row_framebuffer_writer.sv
verif/grfw_screen_checker.sv
verif/testbench.sv
